// ===== hdl/srm_pkg.sv =====
package srm_pkg;

  // machine sizes
  localparam int STACK_DEPTH   = 64;
  localparam int SP_W          = $clog2(STACK_DEPTH);
  localparam int SC_W          = SP_W + 1;
  localparam int GENERAL_COUNT = 20;
  localparam int NUM_REGS      = 5 + GENERAL_COUNT;
  localparam int RF_W          = $clog2(NUM_REGS);
  localparam int RI_W          = 5;
  localparam int DW            = 32;

  // fixed register indexes
  localparam logic [RI_W-1:0] IDX_A = RI_W'(0);
  localparam logic [RI_W-1:0] IDX_B = RI_W'(1);
  localparam logic [RI_W-1:0] IDX_C = RI_W'(2);
  localparam logic [RI_W-1:0] IDX_P = RI_W'(3);

  // input queue
  localparam int QDEPTH = 2;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = QP_W + 1;

  // stream layouts
  localparam int S_DATA_W = 88;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 1;

  typedef enum logic [3:0] {
    CMD_PUSH  = 4'd0,
    CMD_POP   = 4'd1,
    CMD_MOV   = 4'd2,
    CMD_ADD   = 4'd3,
    CMD_SUB   = 4'd4,
    CMD_MUL   = 4'd5,
    CMD_DIV   = 4'd6,
    CMD_PRINT = 4'd7,
    CMD_RET   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DIV0  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [RI_W-1:0] dest;
    logic            a_is_reg;
    logic [RI_W-1:0] a_reg;
    logic [DW-1:0]   a_imm;
    logic            b_is_reg;
    logic [RI_W-1:0] b_reg;
    logic [DW-1:0]   b_imm;
    logic            is_arith;
    logic            is_stack;
  } instr_t;

  typedef struct packed {
    logic          printed;
    logic [DW-1:0] value;
    status_t       status;
  } result_t;

endpackage

// ===== hdl/srm_front.sv =====
module srm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [srm_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [srm_pkg::S_USER_W-1:0]   s_tuser,
  output logic                           q_valid,
  input  logic                           q_ready,
  output srm_pkg::instr_t                q_ins
);

  srm_pkg::instr_t              fifo [srm_pkg::QDEPTH];
  logic [srm_pkg::QP_W-1:0]     wr_ptr;
  logic [srm_pkg::QP_W-1:0]     rd_ptr;
  logic [srm_pkg::QC_W-1:0]     count;
  srm_pkg::instr_t              dec;
  logic                         push;
  logic                         pop;

  // unpack and classify the incoming beat
  always_comb begin
    dec.cmd      = srm_pkg::cmd_t'(s_tdata[3:0]);
    dec.dest     = s_tdata[8:4];
    dec.a_reg    = s_tdata[13:9];
    dec.a_imm    = s_tdata[45:14];
    dec.b_reg    = s_tdata[50:46];
    dec.b_imm    = s_tdata[82:51];
    dec.a_is_reg = s_tuser[0];
    dec.b_is_reg = s_tuser[1];
    dec.is_arith = (dec.cmd == srm_pkg::CMD_ADD) || (dec.cmd == srm_pkg::CMD_SUB) ||
                   (dec.cmd == srm_pkg::CMD_MUL) || (dec.cmd == srm_pkg::CMD_DIV);
    dec.is_stack = (dec.cmd == srm_pkg::CMD_PUSH) || (dec.cmd == srm_pkg::CMD_POP) ||
                   (dec.cmd == srm_pkg::CMD_PRINT);
  end

  assign s_tready = (count != srm_pkg::QC_W'(srm_pkg::QDEPTH));
  assign q_valid  = (count != '0);
  assign q_ins    = fifo[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == srm_pkg::QP_W'(srm_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == srm_pkg::QP_W'(srm_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= dec;
    end
  end

endmodule

// ===== hdl/srm_div.sv =====
module srm_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [srm_pkg::DW-1:0] dividend,
  input  logic [srm_pkg::DW-1:0] divisor,
  output logic                   done,
  output logic [srm_pkg::DW-1:0] quot,
  output logic [srm_pkg::DW-1:0] rem
);

  localparam int CW = $clog2(srm_pkg::DW);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } dstate_t;

  dstate_t                  state;
  logic [CW-1:0]            cnt;
  logic                     na;
  logic                     nb;
  logic [srm_pkg::DW-1:0]   mb;
  logic [srm_pkg::DW-1:0]   quo_r;
  logic [srm_pkg::DW-1:0]   rem_r;
  logic [srm_pkg::DW:0]     rem_t;
  logic [srm_pkg::DW:0]     diff;

  // one quotient bit per cycle, restoring
  assign rem_t = {rem_r, quo_r[srm_pkg::DW-1]};
  assign diff  = rem_t - {1'b0, mb};

  assign done = (state == D_FIN);
  assign quot = (na ^ nb) ? (~quo_r + 1'b1) : quo_r;
  assign rem  = na ? (~rem_r + 1'b1) : rem_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            state <= D_RUN;
            cnt   <= '0;
          end
        end
        D_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(srm_pkg::DW - 1)) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == D_IDLE && start) begin
      na    <= dividend[srm_pkg::DW-1];
      nb    <= divisor[srm_pkg::DW-1];
      quo_r <= dividend[srm_pkg::DW-1] ? (~dividend + 1'b1) : dividend;
      mb    <= divisor[srm_pkg::DW-1] ? (~divisor + 1'b1) : divisor;
      rem_r <= '0;
    end else if (state == D_RUN) begin
      if (!diff[srm_pkg::DW]) begin
        rem_r <= diff[srm_pkg::DW-1:0];
        quo_r <= {quo_r[srm_pkg::DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_t[srm_pkg::DW-1:0];
        quo_r <= {quo_r[srm_pkg::DW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/srm_back.sv =====
module srm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  srm_pkg::instr_t  q_ins,
  output logic             m_valid,
  input  logic             m_ready,
  output srm_pkg::result_t m_res
);

  typedef enum logic [2:0] {
    S_FETCH,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIVC
  } state_t;

  state_t                          state;
  srm_pkg::instr_t                 ins;
  logic [srm_pkg::SC_W-1:0]        cnt;

  logic [srm_pkg::DW-1:0]          rf_mem [srm_pkg::NUM_REGS];
  logic [srm_pkg::NUM_REGS-1:0]    rf_vld;
  logic [srm_pkg::DW-1:0]          rd_a;
  logic [srm_pkg::DW-1:0]          rd_b;
  logic                            rd_a_ok;
  logic                            rd_b_ok;

  logic [srm_pkg::DW-1:0]          stk_mem [srm_pkg::STACK_DEPTH];
  logic [srm_pkg::DW-1:0]          stk_rd;

  logic [srm_pkg::DW-1:0]          mul_q;

  logic                            out_free;
  logic [srm_pkg::DW-1:0]          src_a;
  logic [srm_pkg::DW-1:0]          src_b;
  logic                            full;
  logic                            empty;
  logic                            b_zero;

  logic                            wr_en;
  logic [srm_pkg::RI_W-1:0]        wr_idx;
  logic [srm_pkg::DW-1:0]          wr_data;
  logic                            wr_ok;

  logic                            emit;
  srm_pkg::result_t                res;

  logic                            div_start;
  logic                            div_done;
  logic [srm_pkg::DW-1:0]          div_q;
  logic [srm_pkg::DW-1:0]          div_r;

  assign q_ready  = (state == S_FETCH);
  assign out_free = !m_valid || m_ready;
  assign src_a    = ins.a_is_reg ? (rd_a_ok ? rd_a : '0) : ins.a_imm;
  assign src_b    = ins.b_is_reg ? (rd_b_ok ? rd_b : '0) : ins.b_imm;
  assign full     = (cnt >= srm_pkg::SC_W'(srm_pkg::STACK_DEPTH));
  assign empty    = (cnt == '0);
  assign b_zero   = (src_b == '0);

  assign div_start = (state == S_EXEC) && out_free && (ins.cmd == srm_pkg::CMD_DIV) && !b_zero;

  srm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (src_a),
    .divisor  (src_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // register file write port
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = srm_pkg::IDX_A;
    wr_data = '0;
    unique case (state)
      S_EXEC: begin
        if (out_free) begin
          unique case (ins.cmd)
            srm_pkg::CMD_MOV: begin
              wr_en   = 1'b1;
              wr_idx  = ins.dest;
              wr_data = src_a;
            end
            srm_pkg::CMD_ADD: begin
              wr_en   = 1'b1;
              wr_data = src_a + src_b;
            end
            srm_pkg::CMD_SUB: begin
              wr_en   = 1'b1;
              wr_data = src_a - src_b;
            end
            srm_pkg::CMD_POP: begin
              wr_en   = !empty;
              wr_idx  = srm_pkg::IDX_P;
              wr_data = stk_rd;
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
        end
      end
      S_MUL: begin
        wr_en   = out_free;
        wr_data = mul_q;
      end
      S_DIV: begin
        wr_en   = div_done;
        wr_idx  = srm_pkg::IDX_B;
        wr_data = div_q;
      end
      S_DIVC: begin
        wr_en   = out_free;
        wr_idx  = srm_pkg::IDX_C;
        wr_data = div_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign wr_ok = wr_en && (int'(wr_idx) < srm_pkg::NUM_REGS);

  // result of the finishing cycle
  always_comb begin
    emit        = 1'b0;
    res.printed = 1'b0;
    res.value   = '0;
    res.status  = srm_pkg::ST_OK;
    unique case (state)
      S_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          unique case (ins.cmd)
            srm_pkg::CMD_PUSH: begin
              if (full) begin
                res.status = srm_pkg::ST_FULL;
              end
            end
            srm_pkg::CMD_POP: begin
              if (empty) begin
                res.status = srm_pkg::ST_EMPTY;
              end
            end
            srm_pkg::CMD_PRINT: begin
              if (empty) begin
                res.status = srm_pkg::ST_EMPTY;
              end else begin
                res.printed = 1'b1;
                res.value   = stk_rd;
              end
            end
            srm_pkg::CMD_MUL: begin
              emit = 1'b0;
            end
            srm_pkg::CMD_DIV: begin
              if (b_zero) begin
                res.status = srm_pkg::ST_DIV0;
              end else begin
                emit = 1'b0;
              end
            end
            default: begin
              res.status = srm_pkg::ST_OK;
            end
          endcase
        end
      end
      S_MUL, S_DIVC: begin
        emit = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // sequencer, stack count, valid bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FETCH;
      cnt     <= '0;
      rf_vld  <= '0;
      m_valid <= 1'b0;
    end else begin
      if (emit) begin
        m_valid <= 1'b1;
        m_res   <= res;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      if (wr_ok) begin
        rf_vld[srm_pkg::RF_W'(wr_idx)] <= 1'b1;
      end
      unique case (state)
        S_FETCH: begin
          if (q_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            if (ins.cmd == srm_pkg::CMD_MUL) begin
              state <= S_MUL;
            end else if (div_start) begin
              state <= S_DIV;
            end else begin
              state <= S_FETCH;
            end
            if (ins.cmd == srm_pkg::CMD_PUSH && !full) begin
              cnt <= cnt + 1'b1;
            end else if ((ins.cmd == srm_pkg::CMD_POP || ins.cmd == srm_pkg::CMD_PRINT) &&
                         !empty) begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        S_MUL, S_DIVC: begin
          if (out_free) begin
            state <= S_FETCH;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DIVC;
          end
        end
        default: begin
          state <= S_FETCH;
        end
      endcase
    end
  end

  // operand fetch: registered reads of register file and stack top
  always_ff @(posedge clk) begin
    if (state == S_FETCH && q_valid) begin
      ins     <= q_ins;
      rd_a    <= rf_mem[srm_pkg::RF_W'(q_ins.a_reg)];
      rd_b    <= rf_mem[srm_pkg::RF_W'(q_ins.b_reg)];
      rd_a_ok <= (int'(q_ins.a_reg) < srm_pkg::NUM_REGS) &&
                 rf_vld[srm_pkg::RF_W'(q_ins.a_reg)];
      rd_b_ok <= (int'(q_ins.b_reg) < srm_pkg::NUM_REGS) &&
                 rf_vld[srm_pkg::RF_W'(q_ins.b_reg)];
      stk_rd  <= stk_mem[srm_pkg::SP_W'(cnt - 1'b1)];
    end
    if (wr_ok) begin
      rf_mem[srm_pkg::RF_W'(wr_idx)] <= wr_data;
    end
    if (state == S_EXEC && out_free && ins.cmd == srm_pkg::CMD_PUSH && !full) begin
      stk_mem[srm_pkg::SP_W'(cnt)] <= src_a;
    end
    if (state == S_EXEC) begin
      mul_q <= src_a * src_b;
    end
  end

endmodule

// ===== hdl/stack_register_machine_executor_top.sv =====
// executes one decoded instruction per input beat on a machine with 25 32-bit
// registers (A, B, C, P, T and twenty general registers) and a 64-entry value
// stack; every instruction gives exactly one output beat carrying a print flag,
// the printed value and a status (ok, stack empty, stack full, divide by zero).
// a two-entry input queue decouples the decoder from the execution sequencer,
// so new beats are taken while one executes and while a result waits on m_tready.
// execution per instruction: push, pop, mov, add, sub, print, ret and a divide by
// zero take an operand read, then execute; mul adds a step (the product is
// registered before write back); div waits on the radix-2 divider, which
// produces one quotient bit per cycle over 32 steps, plus setup, sign correction
// and a second register file write for the remainder.
// register file reset is immediate (per-entry valid bits); stack entries are
// only read below the stack count so they need no clearing
module stack_register_machine_executor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[3:0], dest_reg[8:4], a_reg[13:9], a_imm[45:14], b_reg[50:46],
  // b_imm[82:51], zero pad[87:83]
  input  logic [87:0] s_tdata,
  // a_is_reg[0], b_is_reg[1]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // print_value[31:0], status[33:32], zero pad[39:34]
  output logic [39:0] m_tdata,
  // printed[0]
  output logic [0:0]  m_tuser
);

  logic             q_valid;
  logic             q_ready;
  srm_pkg::instr_t  q_ins;
  srm_pkg::result_t res;

  // front: unpack beats into the instruction queue
  srm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_ins    (q_ins)
  );

  // back: operand read, execute, write back and result register
  srm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_ins   (q_ins),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (res)
  );

  // output beat packing
  assign m_tdata = {6'b0, res.status, res.value};
  assign m_tuser = res.printed;

  // a printed beat always reports ok status
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[33:32] == srm_pkg::ST_OK)
    else $error("printed beat with error status");

  // no print means the value field is zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == '0)
    else $error("nonzero value without print");

  // nothing is presented right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

// ===== tb/stack_register_machine_executor_top_test.sv =====
module stack_register_machine_executor_top_test;

  // cycles with no beat on either side before the run is declared hung;
  // the slowest legal quiet stretch is a divide plus a long sender gap
  // plus a long receiver stall, well under this
  localparam int QUIET_LIMIT = 3000;
  // settle time after the last result, longer than the divide latency
  localparam int TAIL_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;

  // one decoded instruction as the sender sees it
  typedef struct {
    logic [3:0]  cmd;
    logic [4:0]  dest;
    logic        a_is_reg;
    logic [4:0]  a_reg;
    logic [31:0] a_imm;
    logic        b_is_reg;
    logic [4:0]  b_reg;
    logic [31:0] b_imm;
  } instr_item_t;

  // shadow machine state, kept in step with accepted instructions
  logic [31:0] mach_regs  [srm_pkg::NUM_REGS];
  logic [31:0] mach_stack [srm_pkg::STACK_DEPTH];
  int          mach_depth;

  // predicted outcome of every accepted instruction, oldest first
  srm_pkg::result_t exec_outcomes[$];

  int          mismatch_count;
  int          quiet_cycles;
  bit          send_gaps_on;
  bit          stall_on;

  stack_register_machine_executor_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // gap length: mostly none, often a few cycles, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // operand values weighted toward the corners of 32-bit arithmetic
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(1, 20));
      5: return -32'($urandom_range(1, 20));
      default: return $urandom();
    endcase
  endfunction

  // register index, mostly inside the file, sometimes past its end
  function automatic logic [4:0] rand_reg();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(srm_pkg::NUM_REGS, 31));
    return 5'($urandom_range(0, srm_pkg::NUM_REGS - 1));
  endfunction

  function automatic instr_item_t instr_of(logic [3:0] cmd, logic [4:0] dest,
                                           logic a_is_reg, logic [4:0] a_reg,
                                           logic [31:0] a_imm, logic b_is_reg,
                                           logic [4:0] b_reg, logic [31:0] b_imm);
    instr_item_t it;
    it.cmd      = cmd;
    it.dest     = dest;
    it.a_is_reg = a_is_reg;
    it.a_reg    = a_reg;
    it.a_imm    = a_imm;
    it.b_is_reg = b_is_reg;
    it.b_reg    = b_reg;
    it.b_imm    = b_imm;
    return it;
  endfunction

  // register reads past the end of the file give zero
  function automatic logic [31:0] operand(logic is_reg, logic [4:0] idx,
                                          logic [31:0] imm);
    if (!is_reg) return imm;
    if (idx < srm_pkg::NUM_REGS) return mach_regs[idx];
    return 32'h0;
  endfunction

  // apply one instruction to the shadow machine and give its outcome
  function automatic srm_pkg::result_t execute_instr(instr_item_t it);
    srm_pkg::result_t res;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quo;
    logic [31:0] rem;
    logic [63:0] prod;
    a           = operand(it.a_is_reg, it.a_reg, it.a_imm);
    b           = operand(it.b_is_reg, it.b_reg, it.b_imm);
    res.printed = 1'b0;
    res.value   = 32'h0;
    res.status  = srm_pkg::ST_OK;
    case (it.cmd)
      srm_pkg::CMD_PUSH: begin
        if (mach_depth >= srm_pkg::STACK_DEPTH) begin
          res.status = srm_pkg::ST_FULL;
        end else begin
          mach_stack[mach_depth] = a;
          mach_depth++;
        end
      end
      srm_pkg::CMD_POP, srm_pkg::CMD_PRINT: begin
        if (mach_depth == 0) begin
          res.status = srm_pkg::ST_EMPTY;
        end else begin
          mach_depth--;
          if (it.cmd == srm_pkg::CMD_POP) begin
            mach_regs[srm_pkg::IDX_P] = mach_stack[mach_depth];
          end else begin
            res.printed = 1'b1;
            res.value   = mach_stack[mach_depth];
          end
        end
      end
      srm_pkg::CMD_MOV: begin
        if (it.dest < srm_pkg::NUM_REGS) mach_regs[it.dest] = a;
      end
      srm_pkg::CMD_ADD: mach_regs[srm_pkg::IDX_A] = a + b;
      srm_pkg::CMD_SUB: mach_regs[srm_pkg::IDX_A] = a - b;
      srm_pkg::CMD_MUL: begin
        prod                      = 64'(a) * 64'(b);
        mach_regs[srm_pkg::IDX_A] = prod[31:0];
      end
      srm_pkg::CMD_DIV: begin
        if (b == 32'h0) begin
          res.status = srm_pkg::ST_DIV0;
        end else begin
          // divide magnitudes, then restore signs: quotient truncates toward
          // zero, remainder follows the dividend
          mag_a = a[31] ? -a : a;
          mag_b = b[31] ? -b : b;
          quo   = mag_a / mag_b;
          rem   = mag_a % mag_b;
          if (a[31] ^ b[31]) quo = -quo;
          if (a[31]) rem = -rem;
          mach_regs[srm_pkg::IDX_B] = quo;
          mach_regs[srm_pkg::IDX_C] = rem;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // present one instruction, hold it until taken, then record its outcome;
  // with no gap valid simply stays high into the next beat
  task automatic send_instr(instr_item_t it);
    int gap;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, it.b_imm, it.b_reg, it.a_imm, it.a_reg, it.dest, it.cmd};
    s_tuser  <= {it.b_is_reg, it.a_is_reg};
    do @(posedge clk); while (!s_tready);
    exec_outcomes.push_back(execute_instr(it));
  endtask

  // stop sending and hold off until every outstanding result is back
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (exec_outcomes.size() != 0) @(posedge clk);
  endtask

  // empty-stack errors, pushes of the extreme values, register reads and
  // writes past the file, prints in stack order
  task automatic test_stack_directed();
    send_gaps_on = 1'b1;
    stall_on     = 1'b1;
    send_instr(instr_of(srm_pkg::CMD_PRINT, 5'd0, 1'b0, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_POP, 5'd0, 1'b0, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_PUSH, 5'd0, 1'b0, 5'd0, 32'h8000_0000,
                        1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_PUSH, 5'd0, 1'b0, 5'd0, 32'h7fff_ffff,
                        1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_MOV, 5'd0, 1'b0, 5'd0, 32'hffff_ffff,
                        1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_PUSH, 5'd0, 1'b1, srm_pkg::IDX_A, 32'h0,
                        1'b0, 5'd0, 32'h0));
    // last general register, then a write that falls off the end of the file
    send_instr(instr_of(srm_pkg::CMD_MOV, 5'd24, 1'b0, 5'd0, 32'h1234_5678,
                        1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_MOV, 5'd31, 1'b0, 5'd0, 32'hdead_beef,
                        1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_PUSH, 5'd0, 1'b1, 5'd31, 32'hffff_ffff,
                        1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_PRINT, 5'd0, 1'b0, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_PRINT, 5'd0, 1'b0, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_POP, 5'd0, 1'b0, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0));
  endtask

  // wrapping add, sub and mul, signed divide corners, divide by zero,
  // ret and the unused command codes; results observed through the stack
  task automatic test_arith_directed();
    send_instr(instr_of(srm_pkg::CMD_ADD, 5'd0, 1'b1, srm_pkg::IDX_P, 32'h0,
                        1'b0, 5'd0, 32'h1));
    send_instr(instr_of(srm_pkg::CMD_SUB, 5'd0, 1'b0, 5'd0, 32'h0,
                        1'b0, 5'd0, 32'h8000_0000));
    send_instr(instr_of(srm_pkg::CMD_MUL, 5'd0, 1'b1, 5'd24, 32'h0,
                        1'b0, 5'd0, 32'hffff_ffff));
    send_instr(instr_of(srm_pkg::CMD_PUSH, 5'd0, 1'b1, srm_pkg::IDX_A, 32'h0,
                        1'b0, 5'd0, 32'h0));
    // most negative over minus one wraps
    send_instr(instr_of(srm_pkg::CMD_DIV, 5'd0, 1'b0, 5'd0, 32'h8000_0000,
                        1'b0, 5'd0, 32'hffff_ffff));
    send_instr(instr_of(srm_pkg::CMD_PUSH, 5'd0, 1'b1, srm_pkg::IDX_B, 32'h0,
                        1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_DIV, 5'd0, 1'b0, 5'd0, -32'd7, 1'b0, 5'd0, 32'd2));
    send_instr(instr_of(srm_pkg::CMD_DIV, 5'd0, 1'b0, 5'd0, 32'd7,
                        1'b1, srm_pkg::IDX_B, 32'h0));
    // zero divisor from an immediate and from a register past the file
    send_instr(instr_of(srm_pkg::CMD_DIV, 5'd0, 1'b0, 5'd0, 32'd5, 1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_DIV, 5'd0, 1'b0, 5'd0, 32'd5, 1'b1, 5'd31, 32'h1));
    send_instr(instr_of(srm_pkg::CMD_MOV, 5'd4, 1'b1, srm_pkg::IDX_B, 32'h0,
                        1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_PUSH, 5'd0, 1'b1, srm_pkg::IDX_C, 32'h0,
                        1'b0, 5'd0, 32'h0));
    send_instr(instr_of(srm_pkg::CMD_RET, 5'd0, 1'b0, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0));
    send_instr(instr_of(4'd9, 5'd0, 1'b1, 5'd1, 32'h0, 1'b1, 5'd2, 32'h0));
    send_instr(instr_of(4'd15, 5'd0, 1'b0, 5'd0, 32'hffff_ffff, 1'b0, 5'd0, 32'hffff_ffff));
    repeat (4) begin
      send_instr(instr_of(srm_pkg::CMD_PRINT, 5'd0, 1'b0, 5'd0, 32'h0,
                          1'b0, 5'd0, 32'h0));
    end
  endtask

  // random programs in phases that fill, drain or hold the stack level so
  // overflow and underflow are both hit, with idling switched per phase
  task automatic test_random_programs(int count);
    instr_item_t it;
    int          n;
    int          stack_mode;
    int          push_pct;
    int          pop_pct;
    int          roll;
    stack_mode = 0;
    for (n = 0; n < count; n++) begin
      if (n % 120 == 0) begin
        stack_mode   = $urandom_range(0, 2);
        send_gaps_on = $urandom_range(0, 3) != 0;
        stall_on     = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 3) == 0) wait_results_done();
      end
      // sender holds off until the block has answered everything
      if (n == count / 2) wait_results_done();
      case (stack_mode)
        1:       begin push_pct = 60; pop_pct = 8;  end
        2:       begin push_pct = 8;  pop_pct = 60; end
        default: begin push_pct = 22; pop_pct = 22; end
      endcase
      it = instr_of(srm_pkg::CMD_RET, rand_reg(), 1'($urandom_range(0, 1)), rand_reg(),
                    rand_word(), 1'($urandom_range(0, 1)), rand_reg(), rand_word());
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        it.cmd = srm_pkg::CMD_PUSH;
      end else if (roll < push_pct + pop_pct) begin
        it.cmd = $urandom_range(0, 2) == 0 ? srm_pkg::CMD_POP : srm_pkg::CMD_PRINT;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4:      it.cmd = srm_pkg::CMD_MOV;
          5, 6, 7:            it.cmd = srm_pkg::CMD_ADD;
          8, 9:               it.cmd = srm_pkg::CMD_SUB;
          10, 11:             it.cmd = srm_pkg::CMD_MUL;
          12, 13, 14, 15, 16: it.cmd = srm_pkg::CMD_DIV;
          17:                 it.cmd = srm_pkg::CMD_RET;
          18:                 it.cmd = 4'($urandom_range(9, 15));
          default:            it.cmd = srm_pkg::CMD_PRINT;
        endcase
      end
      send_instr(it);
    end
  endtask

  // result side: random stalls on m_tready, every result checked in order
  initial begin : result_monitor
    int               stall_left;
    srm_pkg::result_t want;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (exec_outcomes.size() == 0) begin
          $display("%0t: unexpected result beat printed=%0b value=%h status=%0d",
                   $time, m_tuser[0], m_tdata[31:0], m_tdata[33:32]);
          mismatch_count++;
        end else begin
          want = exec_outcomes.pop_front();
          if (m_tuser[0] !== want.printed) begin
            $display("%0t: printed mismatch expected %0b actual %0b",
                     $time, want.printed, m_tuser[0]);
            mismatch_count++;
          end
          if (m_tdata[31:0] !== want.value) begin
            $display("%0t: print_value mismatch expected %h actual %h",
                     $time, want.value, m_tdata[31:0]);
            mismatch_count++;
          end
          if (m_tdata[33:32] !== want.status) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, want.status, m_tdata[33:32]);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (stall_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // hang detection: count cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stack_register_machine_executor_top_test: FAIL");
      $finish;
    end
  end

  initial begin
    // shadow machine starts from the reset state
    foreach (mach_regs[i]) mach_regs[i] = 32'h0;
    foreach (mach_stack[i]) mach_stack[i] = 32'h0;
    mach_depth     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_gaps_on   = 1'b0;
    stall_on       = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_stack_directed();
    test_arith_directed();
    test_random_programs(1075);

    // drain, then leave room for any stray beat
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && exec_outcomes.size() == 0) begin
      $display("stack_register_machine_executor_top_test: PASS");
    end else begin
      $display("stack_register_machine_executor_top_test: FAIL");
    end
    $finish;
  end

endmodule
